@@ hw/rtl/csq_pkg.sv @@
// Package with payload types, fixed-point constants and elaboration-time helpers.
`timescale 1ns / 1ps

package csq_pkg;

    localparam int ANGLE_BITS_DEF   = 32;
    localparam int CORDIC_STEPS_DEF = 24;

    localparam logic [63:0] PI_Q60     = 64'h3243F6A8885A308D;
    localparam logic [63:0] HALF_PI    = PI_Q60 >> 1;
    localparam logic [63:0] INV2PI_Q64 = 64'h28BE60DB9391054A;

    typedef struct packed {
        logic signed [31:0] sample_time;
        logic signed [31:0] peak_time;
        logic        [30:0] half_width;
        logic signed [31:0] carrier_freq;
        logic signed [31:0] carrier_phase;
        logic signed [31:0] amplitude;
    } csq_in_t;

    typedef struct packed {
        logic signed [31:0] field_value;
        logic               bad_width;
    } csq_out_t;

    // Restoring long division, used only when constants are worked out.
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], n[b]};
            if (r >= d) begin
                r    = r - d;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bitv;
        v    = v_in;
        res  = '0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 64'd0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Reciprocal of the CORDIC gain in Q60.
    function automatic logic [63:0] inv_gain_q60(input int steps);
        logic [63:0] p;
        p = 64'd1 << 62;
        for (int i = 0; i < steps && i < 32; i++) begin
            p = p - udiv64(p, (64'd1 << (2 * i)) + 64'd1);
        end
        return isqrt64(p << 2) << 28;
    endfunction

    // atan(2^-i) in Q60 from the integer power series.
    function automatic logic [63:0] atan_q60(input int i);
        logic [63:0] sum;
        logic [63:0] term;
        int          e;
        sum  = '0;
        term = '0;
        if (i == 0) begin
            return PI_Q60 >> 2;
        end
        for (int k = 0; k < 64; k++) begin
            e = i * (2 * k + 1);
            if (e <= 60) begin
                term = udiv64(64'd1 << (60 - e), 64'(2 * k + 1));
                if (k % 2 == 1) sum = sum - term;
                else sum = sum + term;
            end
        end
        return sum;
    endfunction

endpackage

@@ hw/rtl/cos_squared_pulse_sample_core.sv @@
// Top level of the cos-squared pulse sample pipeline.
// The core accepts one request per clock cycle while the result side is not stalled and
// returns one result per request, in order. The envelope divider resolves one quotient
// bit per stage, and the two parallel CORDIC pipelines perform one rotation per stage.
// A stall on the result side holds the whole pipeline.
`timescale 1ns / 1ps

module cos_squared_pulse_sample_core #(
    parameter int ANGLE_BITS   = csq_pkg::ANGLE_BITS_DEF,
    parameter int CORDIC_STEPS = csq_pkg::CORDIC_STEPS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  csq_pkg::csq_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output csq_pkg::csq_out_t m_data
);
    import csq_pkg::*;

    localparam int COS_LAT = CORDIC_STEPS + 3;
    localparam int TOTAL   = ANGLE_BITS + COS_LAT + 3;
    localparam int CAR_DLY = ANGLE_BITS - 4;
    localparam int SIDE_N  = TOTAL - 2;
    localparam int ANG_LSB = 104 - ANGLE_BITS;
    localparam int QW      = ANGLE_BITS - 1;

    typedef struct packed {
        logic signed [31:0] amplitude;
        logic               zero_w;
        logic               outside;
    } side_t;

    logic              en;
    logic [TOTAL:1]    vld_reg;

    // Front stage.
    logic signed [32:0] d_reg;
    logic        [32:0] ad_reg;
    logic        [30:0] w_reg;
    logic signed [31:0] om_reg, ph_reg;
    side_t              side0_reg;
    logic signed [32:0] d_next;
    logic        [32:0] ad_next;

    // Divider.
    logic [31:0]   rem_reg [0:ANGLE_BITS-2];
    logic [QW-1:0] q_reg   [0:ANGLE_BITS-2];
    logic [30:0]   w_pipe  [0:ANGLE_BITS-3];

    // Carrier angle.
    logic [63:0]            rad_reg;
    logic signed [64:0]     rad_prod;
    logic [127:0]           ang_prod;
    logic [ANGLE_BITS-1:0]  ang_reg [0:CAR_DLY-1];

    logic signed [31:0] env_cos, car_cos;
    side_t              side_reg [0:SIDE_N-1];

    logic signed [31:0] env_reg, car_reg, pc_reg;
    logic signed [63:0] env_sq, pc_prod, res_prod;
    logic signed [32:0] res_sh;
    logic signed [31:0] res_sat;
    csq_out_t           out_reg, out_next;

    assign en      = !vld_reg[TOTAL] || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[TOTAL-1:1], s_valid};
        end
    end

    always_comb begin
        d_next  = $signed({s_data.sample_time[31], s_data.sample_time})
                - $signed({s_data.peak_time[31], s_data.peak_time});
        ad_next = d_next[32] ? 33'(-d_next) : d_next;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg             <= d_next;
            ad_reg            <= ad_next;
            w_reg             <= s_data.half_width;
            om_reg            <= s_data.carrier_freq;
            ph_reg            <= s_data.carrier_phase;
            side0_reg.amplitude <= s_data.amplitude;
            side0_reg.zero_w  <= (s_data.half_width == 31'd0);
            side0_reg.outside <= (ad_next > {2'b00, s_data.half_width});
        end
    end

    // Restoring divider for |dt| * 2^(ANGLE_BITS-2) / half_width, one bit per stage.
    always_ff @(posedge aclk) begin
        if (en) begin
            if (ad_reg >= {2'b00, w_reg}) begin
                rem_reg[0] <= 32'(ad_reg - {2'b00, w_reg});
                q_reg[0]   <= QW'(1);
            end else begin
                rem_reg[0] <= ad_reg[31:0];
                q_reg[0]   <= '0;
            end
        end
    end

    for (genvar j = 1; j <= ANGLE_BITS - 2; j++) begin : g_div
        logic [32:0] t;
        logic        ge;
        assign t  = {rem_reg[j-1], 1'b0};
        assign ge = (t >= {2'b00, w_pipe[j-1]});
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j] <= ge ? 32'(t - {2'b00, w_pipe[j-1]}) : t[31:0];
                q_reg[j]   <= {q_reg[j-1][QW-2:0], ge};
            end
        end
    end

    // The divisor travels beside the remainder.
    always_ff @(posedge aclk) begin
        if (en) begin
            w_pipe[0] <= w_reg;
        end
    end
    for (genvar j = 1; j <= ANGLE_BITS - 3; j++) begin : g_wpipe
        always_ff @(posedge aclk) begin
            if (en) begin
                w_pipe[j] <= w_pipe[j-1];
            end
        end
    end

    // Carrier angle in radians (Q40), then in turns.
    assign rad_prod = om_reg * d_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            rad_reg <= rad_prod[63:0] + {{20{ph_reg[31]}}, ph_reg, 12'd0};
        end
    end

    csq_mul64 u_turns (
        .aclk (aclk),
        .en   (en),
        .a    (rad_reg),
        .b    (INV2PI_Q64),
        .neg  (rad_reg[63]),
        .p    (ang_prod)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            ang_reg[0] <= ang_prod[ANG_LSB +: ANGLE_BITS];
        end
    end
    for (genvar k = 1; k < CAR_DLY; k++) begin : g_car
        always_ff @(posedge aclk) begin
            if (en) begin
                ang_reg[k] <= ang_reg[k-1];
            end
        end
    end

    csq_cos #(
        .ANGLE_BITS   (ANGLE_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_env_cos (
        .aclk    (aclk),
        .en      (en),
        .u       ({1'b0, q_reg[ANGLE_BITS-2]}),
        .cos_q30 (env_cos)
    );

    csq_cos #(
        .ANGLE_BITS   (ANGLE_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_car_cos (
        .aclk    (aclk),
        .en      (en),
        .u       (ang_reg[CAR_DLY-1]),
        .cos_q30 (car_cos)
    );

    // Side data waits for the cosines.
    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= side0_reg;
        end
    end
    for (genvar k = 1; k < SIDE_N; k++) begin : g_side
        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign env_sq  = env_cos * env_cos;
    assign pc_prod = env_reg * car_reg;
    assign res_prod = side_reg[SIDE_N-1].amplitude * pc_reg;
    assign res_sh  = res_prod[62:30];

    always_comb begin
        if (res_sh > 33'sd2147483647) res_sat = 32'sh7FFFFFFF;
        else if (res_sh < -33'sd2147483648) res_sat = 32'sh80000000;
        else res_sat = res_sh[31:0];

        out_next.field_value = res_sat;
        out_next.bad_width   = 1'b0;
        if (side_reg[SIDE_N-1].zero_w) begin
            out_next.field_value = '0;
            out_next.bad_width   = 1'b1;
        end else if (side_reg[SIDE_N-1].outside) begin
            out_next.field_value = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            env_reg <= env_sq[61:30];
            car_reg <= car_cos;
            pc_reg  <= pc_prod[61:30];
            out_reg <= out_next;
        end
    end

    assign m_valid = vld_reg[TOTAL];
    assign m_data  = out_reg;

    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.bad_width |-> m_data.field_value == 32'sd0)
        else $error("bad width result carries a non-zero field value");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(vld_reg))
        else $error("pipeline valid bits moved during a stall");

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

@@ hw/rtl/csq_mul64.sv @@
// Two-stage 64 by 64 multiplier built from four 32 by 32 partial products.
`timescale 1ns / 1ps

module csq_mul64 (
    input  logic         aclk,
    input  logic         en,
    input  logic [63:0]  a,
    input  logic [63:0]  b,
    input  logic         neg,
    output logic [127:0] p
);

    logic [63:0]  pp00_reg, pp01_reg, pp10_reg, pp11_reg;
    logic [63:0]  b_reg;
    logic         neg_reg;
    logic [127:0] p_reg;
    logic [127:0] p_next;

    always_ff @(posedge aclk) begin
        if (en) begin
            pp00_reg <= a[31:0]  * b[31:0];
            pp01_reg <= a[31:0]  * b[63:32];
            pp10_reg <= a[63:32] * b[31:0];
            pp11_reg <= a[63:32] * b[63:32];
            b_reg    <= b;
            neg_reg  <= neg;
            p_reg    <= p_next;
        end
    end

    // A negative two's-complement multiplicand subtracts b from the upper half.
    always_comb begin
        p_next = {64'd0, pp00_reg}
               + {32'd0, pp01_reg, 32'd0}
               + {32'd0, pp10_reg, 32'd0}
               + {pp11_reg, 64'd0}
               - (neg_reg ? {b_reg, 64'd0} : 128'd0);
    end

    assign p = p_reg;

endmodule

@@ hw/rtl/csq_cos.sv @@
// Pipelined cosine of a turn fraction: quadrant split, radian scaling and CORDIC.
`timescale 1ns / 1ps

module csq_cos #(
    parameter int ANGLE_BITS   = csq_pkg::ANGLE_BITS_DEF,
    parameter int CORDIC_STEPS = csq_pkg::CORDIC_STEPS_DEF
) (
    input  logic                  aclk,
    input  logic                  en,
    input  logic [ANGLE_BITS-1:0] u,
    output logic signed [31:0]    cos_q30
);
    import csq_pkg::*;

    localparam int FB = ANGLE_BITS - 2;
    localparam logic [63:0] INV_GAIN = inv_gain_q60(CORDIC_STEPS);
    localparam logic signed [63:0] LIM = 64'sd1 <<< 60;

    logic [127:0] z_prod;
    logic [1:0]   quad_reg [0:CORDIC_STEPS+1];
    logic [63:0]  x_reg    [0:CORDIC_STEPS-1];
    logic [63:0]  y_reg    [0:CORDIC_STEPS-1];
    logic [63:0]  z_reg    [0:CORDIC_STEPS-1];
    logic signed [31:0] cos_reg;
    logic signed [63:0] sel_v;
    logic signed [63:0] clamp_v;

    csq_mul64 u_zmul (
        .aclk (aclk),
        .en   (en),
        .a    ({{(64-FB){1'b0}}, u[FB-1:0]}),
        .b    (HALF_PI),
        .neg  (1'b0),
        .p    (z_prod)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            quad_reg[0] <= u[ANGLE_BITS-1:ANGLE_BITS-2];
        end
    end

    for (genvar k = 1; k <= CORDIC_STEPS + 1; k++) begin : g_quad
        always_ff @(posedge aclk) begin
            if (en) begin
                quad_reg[k] <= quad_reg[k-1];
            end
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        localparam logic [63:0] ATAN = atan_q60(i);
        logic [63:0] xi, yi, zi, dx, dy;
        if (i == 0) begin : g_first
            assign xi = INV_GAIN;
            assign yi = 64'd0;
            assign zi = z_prod[FB +: 64];
        end else begin : g_next
            assign xi = x_reg[i-1];
            assign yi = y_reg[i-1];
            assign zi = z_reg[i-1];
        end
        assign dx = 64'($signed(yi) >>> i);
        assign dy = 64'($signed(xi) >>> i);
        always_ff @(posedge aclk) begin
            if (en) begin
                if (zi[63]) begin
                    x_reg[i] <= xi + dx;
                    y_reg[i] <= yi - dy;
                    z_reg[i] <= zi + ATAN;
                end else begin
                    x_reg[i] <= xi - dx;
                    y_reg[i] <= yi + dy;
                    z_reg[i] <= zi - ATAN;
                end
            end
        end
    end

    always_comb begin
        unique case (quad_reg[CORDIC_STEPS+1])
            2'd0:    sel_v = $signed(x_reg[CORDIC_STEPS-1]);
            2'd1:    sel_v = -$signed(y_reg[CORDIC_STEPS-1]);
            2'd2:    sel_v = -$signed(x_reg[CORDIC_STEPS-1]);
            default: sel_v = $signed(y_reg[CORDIC_STEPS-1]);
        endcase
        if (sel_v > LIM) clamp_v = LIM;
        else if (sel_v < -LIM) clamp_v = -LIM;
        else clamp_v = sel_v;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cos_reg <= clamp_v[61:30];
        end
    end

    assign cos_q30 = cos_reg;

endmodule

@@ sim/csq_pulse_checker.sv @@
// Checker for the cos-squared pulse core: predicts each sample and compares the results.
`timescale 1ns / 1ps

module csq_pulse_checker (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  csq_pkg::csq_in_t  s_data,
    input  logic              m_valid,
    input  logic              m_ready,
    input  csq_pkg::csq_out_t m_data,
    output int                fail_count,
    output int                pending
);
    import csq_pkg::*;

    localparam int STEPS = 24;

    logic signed [63:0] atan_tab [STEPS];
    logic signed [63:0] start_x;
    csq_out_t           sample_queue [$];

    function automatic logic [63:0] root64(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] t;
        r = '0;
        for (int b = 31; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= v && t <= 64'hFFFFFFFF) r = t;
        end
        return r;
    endfunction

    initial begin
        logic [63:0] p;
        logic [63:0] acc;
        int          e;
        atan_tab[0] = PI_Q60 >> 2;
        for (int i = 1; i < STEPS; i++) begin
            acc = '0;
            for (int k = 0; i * (2 * k + 1) <= 60; k++) begin
                e = i * (2 * k + 1);
                if (k % 2 == 1) acc = acc - (64'd1 << (60 - e)) / 64'(2 * k + 1);
                else acc = acc + (64'd1 << (60 - e)) / 64'(2 * k + 1);
            end
            atan_tab[i] = acc;
        end
        p = 64'd1 << 62;
        for (int i = 0; i < STEPS && i < 32; i++) p = p - p / ((64'd1 << (2 * i)) + 64'd1);
        start_x = root64(p << 2) << 28;
    end

    // Cosine of a 32-bit fraction of a turn in Q60, clamped to plus or minus one.
    function automatic logic signed [63:0] turn_cos(input logic [31:0] u);
        logic [127:0]       prod;
        logic signed [63:0] x, y, z, dx, dy, v;
        prod = {98'b0, u[29:0]} * {64'b0, HALF_PI};
        z = prod[93:30];
        x = start_x;
        y = '0;
        for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z < 0) begin
                x = x + dx; y = y - dy; z = z + atan_tab[i];
            end else begin
                x = x - dx; y = y + dy; z = z - atan_tab[i];
            end
        end
        case (u[31:30])
            2'd0: v = x;
            2'd1: v = -y;
            2'd2: v = -x;
            default: v = y;
        endcase
        if (v > (64'sd1 <<< 60)) v = 64'sd1 <<< 60;
        if (v < -(64'sd1 <<< 60)) v = -(64'sd1 <<< 60);
        return v;
    endfunction

    function automatic csq_out_t pulse_sample(input csq_in_t a);
        csq_out_t           o;
        logic signed [63:0] d, ad, c1, env, car, pc, res, rad;
        logic [63:0]        w, q;
        logic [127:0]       turn;
        o = '0;
        w = {33'b0, a.half_width};
        if (w == 0) begin
            o.bad_width = 1'b1;
            return o;
        end
        d  = 64'(a.sample_time) - 64'(a.peak_time);
        ad = d < 0 ? -d : d;
        if (ad > $signed(w)) return o;
        q   = (64'(ad) << 30) / w;
        c1  = turn_cos(q[31:0]) >>> 30;
        env = (c1 * c1) >>> 30;
        rad = 64'(a.carrier_freq) * d + 64'(a.carrier_phase) * 64'sd4096;
        turn = {{64{rad[63]}}, rad} * {64'b0, INV2PI_Q64};
        car = turn_cos(turn[103:72]) >>> 30;
        pc  = (env * car) >>> 30;
        res = (64'(a.amplitude) * pc) >>> 30;
        if (res > 64'sd2147483647) res = 64'sd2147483647;
        if (res < -64'sd2147483648) res = -64'sd2147483648;
        o.field_value = res[31:0];
        return o;
    endfunction

    always @(posedge aclk) begin
        csq_out_t want;
        if (!aresetn) begin
            fail_count <= 0;
            pending    <= 0;
        end else begin
            if (s_valid && s_ready) sample_queue.push_back(pulse_sample(s_data));
            if (m_valid && m_ready) begin
                if (sample_queue.size() == 0) begin
                    $display("%0t: result with no request waiting: %h", $time, m_data);
                    fail_count <= fail_count + 1;
                end else begin
                    want = sample_queue.pop_front();
                    if (want.field_value !== m_data.field_value
                        || want.bad_width !== m_data.bad_width) begin
                        $display("%0t: mismatch field_value exp %h got %h, bad_width exp %b got %b",
                                 $time, want.field_value, m_data.field_value,
                                 want.bad_width, m_data.bad_width);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= sample_queue.size();
        end
    end
endmodule

@@ sim/cos_squared_pulse_sample_core_tb.sv @@
// Testbench top: drives pulse sample requests into the core and reports the verdict.
`timescale 1ns / 1ps

module cos_squared_pulse_sample_core_tb;
    import csq_pkg::*;

    localparam int N_RANDOM   = 750;
    localparam int CALM_AFTER = 650;
    localparam int STALL_MAX  = 3000;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    csq_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    csq_out_t m_data;
    int       fail_count;
    int       pending;
    int       sent = 0;
    bit       calm = 1'b0;
    int       quiet_cycles = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    cos_squared_pulse_sample_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    csq_pulse_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .fail_count(fail_count), .pending(pending)
    );

    // Result side stalls in bursts until the final stretch.
    always @(negedge aclk) begin
        int burst;
        if (burst > 0) begin
            burst = burst - 1;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 14);
            m_ready <= 1'b0;
        end else begin
            m_ready <= aresetn;
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
        else quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= STALL_MAX) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Valid stays high between requests sent back to back; the caller drops it when done.
    task automatic send_request(input csq_in_t item);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent = sent + 1;
        @(negedge aclk);
    endtask

    function automatic csq_in_t make_pulse(input logic signed [31:0] dt, input logic [30:0] w,
                                           input logic signed [31:0] amp);
        csq_in_t r;
        r.peak_time     = $urandom;
        r.sample_time   = r.peak_time + dt;
        r.half_width    = w;
        r.carrier_freq  = $urandom;
        r.carrier_phase = $urandom;
        r.amplitude     = amp;
        return r;
    endfunction

    initial begin
        csq_in_t            it;
        logic [30:0]        w;
        logic signed [31:0] dt;
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Zero width, also with the sample on the peak.
        it = make_pulse(0, 31'd0, 32'h1000_0000); send_request(it);
        it = make_pulse(5, 31'd0, -32'sd1); send_request(it);
        // Peak of the pulse with full-scale amplitudes and zero carrier frequency.
        it = '{0, 0, 31'h10000, 0, 0, 32'h8000_0000}; send_request(it);
        it = '{0, 0, 31'h10000, 0, 0, 32'h7FFF_FFFF}; send_request(it);
        it = '{0, 0, 31'h7FFF_FFFF, 0, 32'h3243_F6A8, 32'h8000_0000}; send_request(it);
        // Edge of the pulse on both sides, and just outside it.
        it = '{32'h0001_0000, 0, 31'h10000, 32'h0100_0000, 0, 32'h1000_0000}; send_request(it);
        it = '{-32'sh0001_0000, 0, 31'h10000, 32'h0100_0000, 0, 32'h1000_0000};
        send_request(it);
        it = '{32'h0001_0001, 0, 31'h10000, 0, 0, 32'h1000_0000}; send_request(it);
        it = '{-32'sh0001_0001, 0, 31'h10000, 0, 0, 32'h1000_0000}; send_request(it);
        // Extreme times and widths.
        it = '{32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
               32'h7FFF_FFFF}; send_request(it);
        it = '{32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
               32'h8000_0000}; send_request(it);
        it = '{32'h8000_0000, 32'h8000_0000, 31'd1, 32'h8000_0000, 32'h8000_0000,
               32'h8000_0000}; send_request(it);
        it = '{32'h0000_0001, 0, 31'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
        send_request(it);
        it = '{32'hFFFF_FFFF, 32'h0, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF};
        send_request(it);
        it = '{0, 0, 31'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000}; send_request(it);

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == CALM_AFTER) calm = 1'b1;
            if (n == N_RANDOM / 2) begin
                // Let the pipeline drain completely before carrying on.
                s_valid <= 1'b0;
                @(negedge aclk);
                while (pending != 0) @(negedge aclk);
            end
            if ($urandom_range(0, 4) == 0) begin
                it = 191'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
                if ($urandom_range(0, 9) == 0) it.half_width = 0;
            end else begin
                w = 31'($urandom) >> $urandom_range(0, 30);
                if (w == 0) w = 31'd1;
                dt = $urandom_range(0, w);
                if ($urandom_range(0, 1)) dt = -dt;
                if ($urandom_range(0, 15) == 0) dt = $urandom_range(0, 1) ? 32'(w) : -32'(w);
                it = make_pulse(dt, w, $urandom);
            end
            send_request(it);
        end

        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (100) @(negedge aclk);
        $display("Sent %0d requests: zero widths, pulse edges, outside samples, extremes,", sent);
        $display("random in-pulse samples, with stalls on both sides and one full drain.");
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
